// File: hdl/button_debounce_click_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce click classifier
// Shared property forms, checked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// bdcc_pkg
// Types and constants shared by the button debounce click classifier.
// ----------------------------------------------------------------------------
package bdcc_pkg;

  localparam int unsigned TICK_W          = 32;
  localparam int unsigned SEQ_W           = 32;
  localparam int unsigned AGREE_W         = 4;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned STABLE_POLLS    = 2;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0] RESET_SHORT_LIMIT = 32'd300;
  localparam logic [TICK_W-1:0] RESET_DBL_WINDOW  = 32'd250;

  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DBL_WINDOW  = 2'd1;

  typedef enum logic {
    KEY_OK   = 1'b0,
    KEY_BACK = 1'b1
  } key_t;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_SHORT   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef struct packed {
    key_t             key;
    logic [SEQ_W-1:0] number;
  } report_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hdl/button_debounce_click_classifier_top.sv
// The block takes one poll per clock cycle while in_ready is high (button
// level plus tick time) and turns every recognized click into three
// results, press, short and release, that share one sequence number;
// key_code is 0 for a single click and 1 for a double click. Polls are
// classified combinationally, and the results leave at one per cycle
// while out_ready is high, from an output register. A four-entry report
// queue decouples the two sides: polls keep flowing while results drain,
// and in_ready drops only while that queue is full. The first result of a
// click passes through the queue entry and then the output register.
// ----------------------------------------------------------------------------
// button_debounce_click_classifier_top
// Button debounce and single or double click classifier.
// ----------------------------------------------------------------------------
module button_debounce_click_classifier_top #(
  parameter int unsigned STABLE_POLLS = bdcc_pkg::STABLE_POLLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bdcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bdcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              button_down,
  input  logic [bdcc_pkg::TICK_W-1:0]       now_tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              key_code,
  output logic [1:0]                        event_kind,
  output logic [bdcc_pkg::SEQ_W-1:0]        event_number,
  output logic                              last
);
  import bdcc_pkg::*;

  `include "button_debounce_click_classifier_top_assert.svh"

  q_status_t q_status;
  logic      push;
  report_t   push_data;
  logic      pop;
  report_t   pop_data;

  bdcc_front #(
    .STABLE_POLLS(STABLE_POLLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .button_down(button_down),
    .now_tick   (now_tick),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  bdcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_status (q_status)
  );

  bdcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_data    (pop_data),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_code    (key_code),
    .event_kind  (event_kind),
    .event_number(event_number),
    .last        (last)
  );

  `BDCC_ASSERT_IMP(a_no_overflow, push, !q_status.full, "report pushed into a full queue")
  `BDCC_ASSERT_NXT(a_triple_step, out_valid && out_ready && !last,
    out_valid && (event_number == $past(event_number)) &&
    (event_kind == $past(event_kind) + 2'd1), "result triple broken")
  `BDCC_ASSERT_NXT(a_new_report, out_valid && out_ready && last,
    !out_valid || ((event_kind == KIND_PRESS) && (event_number != $past(event_number))),
    "new report does not start with a fresh press")

endmodule

// File: hdl/bdcc_front.sv
// ----------------------------------------------------------------------------
// bdcc_front
// Debounces each poll, classifies clicks and pushes one report per click.
// ----------------------------------------------------------------------------
module bdcc_front #(
  parameter int unsigned STABLE_POLLS = bdcc_pkg::STABLE_POLLS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bdcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bdcc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 button_down,
  input  logic [bdcc_pkg::TICK_W-1:0]          now_tick,
  input  bdcc_pkg::q_status_t                  q_status,
  output logic                                 push,
  output bdcc_pkg::report_t                    push_data
);
  import bdcc_pkg::*;

  localparam logic [AGREE_W-1:0] POLLS = AGREE_W'(STABLE_POLLS);

  logic [TICK_W-1:0]  short_limit;
  logic [TICK_W-1:0]  dbl_window;
  logic               raw_level, raw_level_next;
  logic               stable_level, stable_level_next;
  logic [AGREE_W-1:0] agree_count, agree_count_next;
  logic [TICK_W-1:0]  press_time, press_time_next;
  logic               click_pending, click_pending_next;
  logic               second_started, second_started_next;
  logic [TICK_W-1:0]  release_time, release_time_next;
  logic [SEQ_W-1:0]   event_sequence, event_sequence_next;
  logic               report;
  key_t               report_key;
  logic               accept;
  logic [TICK_W-1:0]  press_elapsed;
  logic [TICK_W-1:0]  window_elapsed;
  logic               change;

  assign in_ready       = !q_status.full;
  assign accept         = in_valid && in_ready;
  assign press_elapsed  = now_tick - press_time;
  assign window_elapsed = now_tick - release_time;

  always_comb begin
    raw_level_next      = raw_level;
    agree_count_next    = agree_count;
    stable_level_next   = stable_level;
    press_time_next     = press_time;
    click_pending_next  = click_pending;
    second_started_next = second_started;
    release_time_next   = release_time;
    report              = 1'b0;
    report_key          = KEY_OK;

    if (button_down == raw_level) begin
      if (agree_count < POLLS) begin
        agree_count_next = agree_count + AGREE_W'(1);
      end
    end else begin
      raw_level_next   = button_down;
      agree_count_next = AGREE_W'(1);
    end

    change = (agree_count_next >= POLLS) && (stable_level != raw_level_next);

    if (change) begin
      stable_level_next = raw_level_next;
      if (raw_level_next) begin
        press_time_next = now_tick;
        if (click_pending) begin
          second_started_next = 1'b1;
        end
      end else if (press_elapsed > short_limit) begin
        report              = click_pending && second_started;
        report_key          = KEY_OK;
        click_pending_next  = 1'b0;
        second_started_next = 1'b0;
        release_time_next   = '0;
      end else if (!click_pending) begin
        click_pending_next  = 1'b1;
        second_started_next = 1'b0;
        release_time_next   = now_tick;
      end else if (window_elapsed <= dbl_window) begin
        report              = 1'b1;
        report_key          = KEY_BACK;
        click_pending_next  = 1'b0;
        second_started_next = 1'b0;
        release_time_next   = '0;
      end else begin
        report              = 1'b1;
        report_key          = KEY_OK;
        click_pending_next  = 1'b1;
        second_started_next = 1'b0;
        release_time_next   = now_tick;
      end
    end else if (click_pending && !second_started && (window_elapsed > dbl_window)) begin
      report              = 1'b1;
      report_key          = KEY_OK;
      click_pending_next  = 1'b0;
      second_started_next = 1'b0;
      release_time_next   = '0;
    end

    event_sequence_next = report ? event_sequence + SEQ_W'(1) : event_sequence;
  end

  assign push             = accept && report;
  assign push_data.key    = report_key;
  assign push_data.number = event_sequence_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit <= RESET_SHORT_LIMIT;
      dbl_window  <= RESET_DBL_WINDOW;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHORT_LIMIT: short_limit <= cfg_data;
        REG_DBL_WINDOW:  dbl_window  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level      <= 1'b0;
      stable_level   <= 1'b0;
      agree_count    <= POLLS;
      press_time     <= '0;
      click_pending  <= 1'b0;
      second_started <= 1'b0;
      release_time   <= '0;
      event_sequence <= '0;
    end else if (accept) begin
      raw_level      <= raw_level_next;
      stable_level   <= stable_level_next;
      agree_count    <= agree_count_next;
      press_time     <= press_time_next;
      click_pending  <= click_pending_next;
      second_started <= second_started_next;
      release_time   <= release_time_next;
      event_sequence <= event_sequence_next;
    end
  end

endmodule

// File: hdl/bdcc_queue.sv
// ----------------------------------------------------------------------------
// bdcc_queue
// Small register queue of pending reports between front and back.
// ----------------------------------------------------------------------------
module bdcc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bdcc_pkg::report_t   push_data,
  input  logic                pop,
  output bdcc_pkg::report_t   pop_data,
  output bdcc_pkg::q_status_t q_status
);
  import bdcc_pkg::*;

  report_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign q_status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/bdcc_back.sv
// ----------------------------------------------------------------------------
// bdcc_back
// Expands each queued report into its press, short and release results.
// ----------------------------------------------------------------------------
module bdcc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  bdcc_pkg::report_t           pop_data,
  input  bdcc_pkg::q_status_t         q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        key_code,
  output logic [1:0]                  event_kind,
  output logic [bdcc_pkg::SEQ_W-1:0]  event_number,
  output logic                        last
);
  import bdcc_pkg::*;

  logic             busy;
  key_t             key;
  kind_t            kind;
  logic [SEQ_W-1:0] number;
  logic             done;

  assign done         = busy && out_ready && (kind == KIND_RELEASE);
  assign pop          = !q_status.empty && (!busy || done);
  assign out_valid    = busy;
  assign key_code     = key;
  assign event_kind   = kind;
  assign event_number = number;
  assign last         = (kind == KIND_RELEASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      kind <= KIND_PRESS;
    end else if (pop) begin
      busy <= 1'b1;
      kind <= KIND_PRESS;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && out_ready) begin
      case (kind)
        KIND_PRESS: kind <= KIND_SHORT;
        KIND_SHORT: kind <= KIND_RELEASE;
        default:    kind <= KIND_RELEASE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key    <= pop_data.key;
      number <= pop_data.number;
    end
  end

endmodule
